>>> src/tdpd_pkg.sv
// Package with shared types and constants for the trial-division prime divisor block.
`timescale 1ns / 1ps

package tdpd_pkg;

    // Width of the number and prime ports.
    localparam int NUM_W       = 32;
    // Widest working width supported, used for explicit extension.
    localparam int MAX_W       = 64;
    // Most primes emitted for one request, and the counter that tracks them.
    localparam int MAX_RESULTS = 9;
    localparam int CNT_W       = 4;

    // Source of a recorded prime.
    localparam logic [1:0] SRC_TWO = 2'd0;
    localparam logic [1:0] SRC_D   = 2'd1;
    localparam logic [1:0] SRC_VAL = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       shift2;
        logic       div_start;
        logic       take_q;
        logic       d_inc;
        logic       rec;
        logic [1:0] src;
        logic       emit_final;
        logic       emit_none;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic val_lt2;
        logic val_even;
        logic div_done;
        logic d_gt_q;
        logic r_zero;
        logic cnt_full;
        logic out_free;
    } t_status;

endpackage

>>> src/tdpd_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module tdpd_div #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quo,
    output logic [WIDTH-1:0] o_rem
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             ge;

    assign trial = {r_rem, r_quo[WIDTH-1]};
    assign diff  = trial - {1'b0, i_divisor};
    assign ge    = (trial >= {1'b0, i_divisor});

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_cnt  = CW'(WIDTH);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // The remainder stays below the divisor, so it fits in WIDTH bits.
            n_rem = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            n_quo = {r_quo[WIDTH-2:0], ge};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

`ifndef SYNTH
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && r_cnt == CW'(0))
        else $error("divider done while still iterating");
`endif

endmodule

>>> src/tdpd_dp.sv
// Datapath: working value, trial divisor, pending prime, divider and result register.
`timescale 1ns / 1ps

module tdpd_dp #(
    parameter int WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [tdpd_pkg::NUM_W-1:0] i_number,
    input  tdpd_pkg::t_cmd            i_cmd,
    output tdpd_pkg::t_status         o_sts,
    input  logic                      i_out_ready,
    output logic [tdpd_pkg::NUM_W-1:0] o_prime,
    output logic                      o_found,
    output logic                      o_last,
    output logic                      o_valid
);

    logic [WIDTH-1:0]                 r_val;
    logic [WIDTH-1:0]                 r_d;
    logic [WIDTH-1:0]                 r_pend;
    logic                             r_has_pend;
    logic [tdpd_pkg::CNT_W-1:0]       r_cnt;
    logic [tdpd_pkg::NUM_W-1:0]       r_prime;
    logic                             r_found;
    logic                             r_last;
    logic                             r_o_valid;

    logic [tdpd_pkg::MAX_W-1:0]       num_ext;
    logic [tdpd_pkg::MAX_W-1:0]       pend_ext;
    logic [WIDTH-1:0]                 src_val;
    logic                             div_done;
    logic [WIDTH-1:0]                 div_q;
    logic [WIDTH-1:0]                 div_r;
    logic                             out_free;

    assign num_ext  = tdpd_pkg::MAX_W'(i_number);
    assign pend_ext = tdpd_pkg::MAX_W'(r_pend);
    assign out_free = !r_o_valid || i_out_ready;

    tdpd_div #(
        .WIDTH (WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_val),
        .i_divisor  (r_d),
        .o_done     (div_done),
        .o_quo      (div_q),
        .o_rem      (div_r)
    );

    always_comb begin
        case (i_cmd.src)
            tdpd_pkg::SRC_TWO: src_val = WIDTH'(2);
            tdpd_pkg::SRC_D:   src_val = r_d;
            default:           src_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val <= num_ext[WIDTH-1:0];
            r_d   <= WIDTH'(3);
        end else begin
            if (i_cmd.shift2) begin
                r_val <= r_val >> 1;
            end
            if (i_cmd.take_q) begin
                r_val <= div_q;
            end
            if (i_cmd.d_inc) begin
                r_d <= r_d + WIDTH'(2);
            end
        end
        if (i_cmd.rec) begin
            r_pend <= src_val;
        end
    end

    // Result register and the bookkeeping of the held-back prime.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid  <= 1'b0;
            r_has_pend <= 1'b0;
            r_cnt      <= '0;
        end else begin
            if (i_cmd.emit_final || i_cmd.emit_none || (i_cmd.rec && r_has_pend)) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cmd.load) begin
                r_has_pend <= 1'b0;
                r_cnt      <= '0;
            end
            if (i_cmd.rec) begin
                r_has_pend <= 1'b1;
                r_cnt      <= r_cnt + tdpd_pkg::CNT_W'(1);
            end
            if (i_cmd.emit_final || i_cmd.emit_none) begin
                r_has_pend <= 1'b0;
            end
        end
        if (i_cmd.rec && r_has_pend) begin
            r_prime <= pend_ext[tdpd_pkg::NUM_W-1:0];
            r_found <= 1'b1;
            r_last  <= 1'b0;
        end
        if (i_cmd.emit_final) begin
            r_prime <= pend_ext[tdpd_pkg::NUM_W-1:0];
            r_found <= 1'b1;
            r_last  <= 1'b1;
        end
        if (i_cmd.emit_none) begin
            r_prime <= '0;
            r_found <= 1'b0;
            r_last  <= 1'b1;
        end
    end

    assign o_sts.val_lt2  = ((r_val >> 1) == '0);
    assign o_sts.val_even = !r_val[0];
    assign o_sts.div_done = div_done;
    assign o_sts.d_gt_q   = (r_d > div_q);
    assign o_sts.r_zero   = (div_r == '0);
    assign o_sts.cnt_full = (r_cnt == tdpd_pkg::CNT_W'(tdpd_pkg::MAX_RESULTS));
    assign o_sts.out_free = out_free;

    assign o_prime = r_prime;
    assign o_found = r_found;
    assign o_last  = r_last;
    assign o_valid = r_o_valid;

endmodule

>>> src/tdpd_ctrl.sv
// Controller state machine that sequences the trial division.
`timescale 1ns / 1ps

module tdpd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  tdpd_pkg::t_status i_sts,
    output tdpd_pkg::t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_REC2  = 4'd2;
    localparam logic [3:0] S_TWO   = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_DWAIT = 4'd5;
    localparam logic [3:0] S_CHK   = 4'd6;
    localparam logic [3:0] S_RECD  = 4'd7;
    localparam logic [3:0] S_END   = 4'd8;
    localparam logic [3:0] S_RECV  = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;
    localparam logic [3:0] S_NONE  = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_strip, n_strip;

    always_comb begin
        n_state = r_state;
        n_strip = r_strip;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_strip    = 1'b0;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_sts.val_lt2) begin
                    n_state = S_NONE;
                end else if (i_sts.val_even) begin
                    n_state = S_REC2;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_REC2: begin
                if (i_sts.out_free) begin
                    o_cmd.rec = 1'b1;
                    o_cmd.src = tdpd_pkg::SRC_TWO;
                    n_state   = S_TWO;
                end
            end
            S_TWO: begin
                if (i_sts.val_even) begin
                    o_cmd.shift2 = 1'b1;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_strip) begin
                    if (i_sts.r_zero) begin
                        o_cmd.take_q = 1'b1;
                    end else begin
                        o_cmd.d_inc = 1'b1;
                        n_strip     = 1'b0;
                    end
                    n_state = S_DIV;
                end else if (i_sts.d_gt_q) begin
                    n_state = S_END;
                end else if (i_sts.r_zero) begin
                    o_cmd.take_q = 1'b1;
                    n_strip      = 1'b1;
                    n_state      = i_sts.cnt_full ? S_DIV : S_RECD;
                end else begin
                    o_cmd.d_inc = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_RECD: begin
                if (i_sts.out_free) begin
                    o_cmd.rec = 1'b1;
                    o_cmd.src = tdpd_pkg::SRC_D;
                    n_state   = S_DIV;
                end
            end
            S_END: begin
                if (!i_sts.val_lt2 && !i_sts.cnt_full) begin
                    n_state = S_RECV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RECV: begin
                if (i_sts.out_free) begin
                    o_cmd.rec = 1'b1;
                    o_cmd.src = tdpd_pkg::SRC_VAL;
                    n_state   = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_final = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_NONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_none = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_strip = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_strip <= 1'b0;
        end else begin
            r_state <= n_state;
            r_strip <= n_strip;
        end
    end

    assign o_ready = (r_state == S_IDLE);

`ifndef SYNTH
    a_idle_no_strip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_strip)
        else $error("divide-out mode left set at end of request");
`endif

endmodule

>>> src/trial_division_prime_divisors_top.sv
// Top level of the trial-division prime divisor block.
`timescale 1ns / 1ps

// Each trial divisor takes a pass of the shared restoring divider, one more for each time
// it is divided out, and the controller checks the quotient and remainder after each
// pass; inputs below two finish without a pass.
// One request is worked at a time; a new one is taken once the final result is in the
// output register, even while that result still waits. Reset is synchronous and active
// low, clears the controller, divider and output valid, and needs no clearing pass.
//
// The controller strips factors of two by shifting, then walks odd divisors d from
// three. Each divider pass gives val / d and val % d: the search ends when d exceeds
// the quotient, and a zero remainder records d and keeps dividing it out. Each prime
// is held back one step so that the last flag can be set on the final result; a value
// above one left at the end is itself prime and comes last. At most nine primes are
// reported for one request.

module trial_division_prime_divisors_top #(
    parameter int WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [tdpd_pkg::NUM_W-1:0] i_number,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [tdpd_pkg::NUM_W-1:0] o_prime,
    output logic                      o_found,
    output logic                      o_last
);

    tdpd_pkg::t_cmd    cmd;
    tdpd_pkg::t_status sts;

    tdpd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tdpd_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_number    (i_number),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_ready),
        .o_prime     (o_prime),
        .o_found     (o_found),
        .o_last      (o_last),
        .o_valid     (o_valid)
    );

`ifndef SYNTH
    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_last && o_prime == '0)
        else $error("empty result must be final and carry zero");
    a_found_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> o_prime[tdpd_pkg::NUM_W-1:1] != '0)
        else $error("reported prime below two");
`endif

endmodule
